### design/gfw_pkg.sv
// ----------------------------------------------------------------------------
// gfw_pkg
// Shared types, codes and constants of the gps fix health watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package gfw_pkg;

    localparam int CFG_DATA_W  = 26;
    localparam int CFG_INDEX_W = 3;
    localparam int THRESH_W    = 16;
    localparam int HOLD_W      = 26;
    localparam int COUNT_W     = 32;
    localparam int FIELD_W     = 16;

    localparam logic [FIELD_W-1:0] MAX_ELAPSED_MS     = 16'd10000;
    localparam logic [FIELD_W-1:0] DEFAULT_ELAPSED_MS = 16'd1000;

    localparam logic [THRESH_W-1:0] SILENT_AFTER_S_RST   = 16'd5;
    localparam logic [THRESH_W-1:0] ACCURACY_WARN_CM_RST = 16'd2500;
    localparam logic [HOLD_W-1:0]   RECOVERY_HOLD_MS_RST = 26'd5000;
    localparam logic [HOLD_W-1:0]   DEGRADED_HOLD_MS_RST = 26'd10000;
    localparam logic [HOLD_W-1:0]   LOST_HOLD_MS_RST     = 26'd5000;
    localparam logic [HOLD_W-1:0]   SILENT_HOLD_MS_RST   = 26'd3000;

    typedef enum logic
    {
        CMD_UPDATE = 1'b0,
        CMD_TAKE   = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        TIER_GOOD     = 2'd0,
        TIER_DEGRADED = 2'd1,
        TIER_LOST     = 2'd2,
        TIER_SILENT   = 2'd3
    } tier_t;

    typedef enum logic [2:0]
    {
        EV_NONE        = 3'd0,
        EV_DEGRADED    = 3'd1,
        EV_LOST        = 3'd2,
        EV_SILENT      = 3'd3,
        EV_REACQUIRED  = 3'd4
    } event_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        REG_SILENT_AFTER_S   = 3'd0,
        REG_ACCURACY_WARN_CM = 3'd1,
        REG_RECOVERY_HOLD_MS = 3'd2,
        REG_DEGRADED_HOLD_MS = 3'd3,
        REG_LOST_HOLD_MS     = 3'd4,
        REG_SILENT_HOLD_MS   = 3'd5
    } cfg_idx_t;

    typedef struct packed
    {
        logic               cmd;
        logic               fix_valid;
        logic [FIELD_W-1:0] accuracy_cm;
        logic [FIELD_W-1:0] stale_s;
        logic [FIELD_W-1:0] elapsed_ms;
    } sample_t;

    typedef struct packed
    {
        logic [2:0]         event_res;
        logic [1:0]         current_tier;
        logic [COUNT_W-1:0] outage_ms;
    } result_t;

    function automatic event_t tier_event(input tier_t tier);
        event_t ev;
        case (tier)
            TIER_DEGRADED: ev = EV_DEGRADED;
            TIER_LOST:     ev = EV_LOST;
            TIER_SILENT:   ev = EV_SILENT;
            default:       ev = EV_NONE;
        endcase
        return ev;
    endfunction

endpackage

`default_nettype wire

### design/gfw_sample_if.sv
// ----------------------------------------------------------------------------
// gfw_sample_if
// Valid/ready channel carrying one health sample or take word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfw_sample_if
    import gfw_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/gfw_result_if.sv
// ----------------------------------------------------------------------------
// gfw_result_if
// Valid/ready channel carrying one watchdog result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfw_result_if
    import gfw_pkg::*;
;
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/gps_fix_health_watchdog.sv
// ----------------------------------------------------------------------------
// gps_fix_health_watchdog
// GPS fix health watchdog with tier escalation and recovery hysteresis.
// ----------------------------------------------------------------------------
// Each accepted word gives exactly one result word, registered in the cycle
// after acceptance. The block takes one word per clock for as long as the
// result side keeps taking results; when a result is held, the next word
// waits in front of the single result register. The figure is set by one
// pass of saturating add, threshold compare and tier select per word, with
// all tracking state updated at the same edge as the result register.
// Thresholds come out of reset at 5 s silent, 2500 cm accuracy, 5000 ms
// recovery, and 10000 / 5000 / 3000 ms degraded / lost / silent holds.
`default_nettype none

module gps_fix_health_watchdog
    import gfw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    gfw_sample_if.sink                  sample,
    gfw_result_if.source                result
);

    logic [THRESH_W-1:0] silent_after_s_reg;
    logic [THRESH_W-1:0] accuracy_warn_cm_reg;
    logic [HOLD_W-1:0]   recovery_hold_ms_reg;
    logic [HOLD_W-1:0]   degraded_hold_ms_reg;
    logic [HOLD_W-1:0]   lost_hold_ms_reg;
    logic [HOLD_W-1:0]   silent_hold_ms_reg;

    logic                seen_first_fix_reg, seen_first_fix_next;
    logic [COUNT_W-1:0]  good_time_ms_reg, good_time_ms_next;
    logic [COUNT_W-1:0]  bad_time_ms_reg, bad_time_ms_next;
    tier_t               worst_tier_reg, worst_tier_next;
    tier_t               announced_tier_reg, announced_tier_next;
    event_t              pending_event_reg, pending_event_next;
    logic [COUNT_W-1:0]  last_outage_ms_reg, last_outage_ms_next;

    logic                res_valid_reg;
    result_t             res_data_reg, res_data_next;

    logic                accept;
    logic [FIELD_W-1:0]  dt;
    tier_t               tier;
    logic [COUNT_W:0]    good_sum;
    logic [COUNT_W:0]    bad_sum;
    logic [HOLD_W-1:0]   hold;
    event_t              ev;

    assign sample.ready = !res_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;
    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silent_after_s_reg   <= SILENT_AFTER_S_RST;
            accuracy_warn_cm_reg <= ACCURACY_WARN_CM_RST;
            recovery_hold_ms_reg <= RECOVERY_HOLD_MS_RST;
            degraded_hold_ms_reg <= DEGRADED_HOLD_MS_RST;
            lost_hold_ms_reg     <= LOST_HOLD_MS_RST;
            silent_hold_ms_reg   <= SILENT_HOLD_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_SILENT_AFTER_S:   silent_after_s_reg   <= cfg_data[THRESH_W-1:0];
                REG_ACCURACY_WARN_CM: accuracy_warn_cm_reg <= cfg_data[THRESH_W-1:0];
                REG_RECOVERY_HOLD_MS: recovery_hold_ms_reg <= cfg_data[HOLD_W-1:0];
                REG_DEGRADED_HOLD_MS: degraded_hold_ms_reg <= cfg_data[HOLD_W-1:0];
                REG_LOST_HOLD_MS:     lost_hold_ms_reg     <= cfg_data[HOLD_W-1:0];
                REG_SILENT_HOLD_MS:   silent_hold_ms_reg   <= cfg_data[HOLD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // one pass over the accepted word
    always_comb
    begin
        seen_first_fix_next = seen_first_fix_reg;
        good_time_ms_next   = good_time_ms_reg;
        bad_time_ms_next    = bad_time_ms_reg;
        worst_tier_next     = worst_tier_reg;
        announced_tier_next = announced_tier_reg;
        pending_event_next  = pending_event_reg;
        last_outage_ms_next = last_outage_ms_reg;
        ev                  = EV_NONE;
        hold                = '0;

        if (sample.data.elapsed_ms == '0 || sample.data.elapsed_ms > MAX_ELAPSED_MS)
        begin
            dt = DEFAULT_ELAPSED_MS;
        end
        else
        begin
            dt = sample.data.elapsed_ms;
        end

        if (sample.data.stale_s >= silent_after_s_reg)
        begin
            tier = TIER_SILENT;
        end
        else if (!sample.data.fix_valid)
        begin
            tier = TIER_LOST;
        end
        else if (sample.data.accuracy_cm >= accuracy_warn_cm_reg)
        begin
            tier = TIER_DEGRADED;
        end
        else
        begin
            tier = TIER_GOOD;
        end

        good_sum = {1'b0, good_time_ms_reg} + {{(COUNT_W+1-FIELD_W){1'b0}}, dt};
        bad_sum  = {1'b0, bad_time_ms_reg} + {{(COUNT_W+1-FIELD_W){1'b0}}, dt};

        if (cmd_t'(sample.data.cmd) == CMD_TAKE)
        begin
            ev                 = pending_event_reg;
            pending_event_next = EV_NONE;
        end
        else if (!seen_first_fix_reg)
        begin
            seen_first_fix_next = sample.data.fix_valid;
        end
        else
        begin
            if (tier == TIER_GOOD)
            begin
                good_time_ms_next = good_sum[COUNT_W] ? '1 : good_sum[COUNT_W-1:0];
            end
            else
            begin
                good_time_ms_next = '0;
                bad_time_ms_next  = bad_sum[COUNT_W] ? '1 : bad_sum[COUNT_W-1:0];
                if (tier > worst_tier_reg)
                begin
                    worst_tier_next = tier;
                end
            end

            case (worst_tier_next)
                TIER_DEGRADED: hold = degraded_hold_ms_reg;
                TIER_LOST:     hold = lost_hold_ms_reg;
                TIER_SILENT:   hold = silent_hold_ms_reg;
                default:       hold = '0;
            endcase

            if (good_time_ms_next >= {{(COUNT_W-HOLD_W){1'b0}}, recovery_hold_ms_reg})
            begin
                if (announced_tier_reg != TIER_GOOD)
                begin
                    last_outage_ms_next = bad_time_ms_next;
                    pending_event_next  = EV_REACQUIRED;
                end
                announced_tier_next = TIER_GOOD;
                worst_tier_next     = TIER_GOOD;
                bad_time_ms_next    = '0;
            end
            else if (worst_tier_next > announced_tier_reg &&
                     bad_time_ms_next >= {{(COUNT_W-HOLD_W){1'b0}}, hold})
            begin
                announced_tier_next = worst_tier_next;
                pending_event_next  = tier_event(worst_tier_next);
            end
        end

        res_data_next.event_res    = ev;
        res_data_next.current_tier = announced_tier_next;
        res_data_next.outage_ms    = last_outage_ms_next;
    end

    // tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_first_fix_reg <= 1'b0;
            good_time_ms_reg   <= '0;
            bad_time_ms_reg    <= '0;
            worst_tier_reg     <= TIER_GOOD;
            announced_tier_reg <= TIER_GOOD;
            pending_event_reg  <= EV_NONE;
            last_outage_ms_reg <= '0;
        end
        else if (accept)
        begin
            seen_first_fix_reg <= seen_first_fix_next;
            good_time_ms_reg   <= good_time_ms_next;
            bad_time_ms_reg    <= bad_time_ms_next;
            worst_tier_reg     <= worst_tier_next;
            announced_tier_reg <= announced_tier_next;
            pending_event_reg  <= pending_event_next;
            last_outage_ms_reg <= last_outage_ms_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_data_reg <= res_data_next;
        end
    end

endmodule

`default_nettype wire

### design/gfw_checker.sv
// ----------------------------------------------------------------------------
// gfw_checker
// Port-level checks of the gps fix health watchdog, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gfw_checker
    import gfw_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    in_valid,
    input wire logic    in_ready,
    input wire logic    out_valid,
    input wire logic    out_ready,
    input wire result_t out_data
);

    a_word_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result word without an accepted input word");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result held");

    a_reacquired_is_good: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.event_res == EV_REACQUIRED) |->
            out_data.current_tier == TIER_GOOD)
        else $error("reacquired event with a bad tier announced");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result word dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_data))
        else $error("result word changed while stalled");

endmodule

bind gps_fix_health_watchdog gfw_checker u_gfw_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

`default_nettype wire
